[sv/lerb_pkg.sv]
// shared types, constants and ring position helpers for the line edit receive buffer
`default_nettype none

package lerb_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned PTR_W = $clog2(2 * DEPTH);
  localparam int unsigned SPAN  = 2 * DEPTH;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(SPAN - 1);
  localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
  localparam logic [PTR_W:0]   SPAN_X    = (PTR_W + 1)'(SPAN);
  localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(DEPTH);

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_DATA = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ACT_ECHO,
    ACT_ERASE,
    ACT_READ,
    ACT_EMPTY
  } act_e;

  typedef struct packed {
    logic       valid;
    act_e       act;
    logic [7:0] ch;
  } act_t;

  function automatic logic [PTR_W-1:0] pos_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] pos_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] pos_idx(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] t;
    t = (p >= PTR_DEPTH) ? p - PTR_DEPTH : p;
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [PTR_W:0] pos_dist(input logic [PTR_W-1:0] from,
                                              input logic [PTR_W-1:0] to);
    logic [PTR_W:0] t;
    t = {1'b0, to} + SPAN_X - {1'b0, from};
    return (t >= SPAN_X) ? t - SPAN_X : t;
  endfunction

endpackage

`default_nettype wire

[sv/lerb_ctrl.sv]
// byte classification, ring pointers and character store
`default_nettype none

module lerb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          op_i,
  input  wire logic [7:0]    rx_byte_i,
  output lerb_pkg::act_t     act_o,
  output logic [7:0]         rd_data_o
);

  logic [7:0] char_store [lerb_pkg::DEPTH];

  logic [lerb_pkg::PTR_W-1:0] read_q, read_d;
  logic [lerb_pkg::PTR_W-1:0] write_q, write_d;
  logic [lerb_pkg::PTR_W-1:0] commit_q, commit_d;
  logic [7:0]                 rd_q;

  logic [7:0] ch;
  logic       is_erase;
  logic       is_print;
  logic       can_erase;
  logic       full;
  logic       has_data;
  logic       do_write;
  logic       do_read;

  always_comb begin
    ch        = (rx_byte_i == lerb_pkg::CH_CR) ? lerb_pkg::CH_LF : rx_byte_i;
    is_erase  = (rx_byte_i == lerb_pkg::CH_BS) || (rx_byte_i == lerb_pkg::CH_DEL);
    is_print  = (ch == lerb_pkg::CH_LF) ||
                ((ch >= lerb_pkg::CH_SP) && (ch <= lerb_pkg::CH_TILDE));
    can_erase = (write_q != commit_q);
    full      = lerb_pkg::pos_dist(read_q, write_q) >= lerb_pkg::DEPTH_X;
    has_data  = (read_q != commit_q);

    read_d    = read_q;
    write_d   = write_q;
    commit_d  = commit_q;
    do_write  = 1'b0;
    do_read   = 1'b0;
    act_o     = '{valid: 1'b0, act: lerb_pkg::ACT_EMPTY, ch: ch};

    if (accept_i) begin
      if (op_i == lerb_pkg::OP_READ) begin
        act_o.valid = 1'b1;
        if (has_data) begin
          do_read   = 1'b1;
          read_d    = lerb_pkg::pos_inc(read_q);
          act_o.act = lerb_pkg::ACT_READ;
        end else begin
          act_o.act = lerb_pkg::ACT_EMPTY;
        end
      end else if (is_erase) begin
        if (can_erase) begin
          write_d     = lerb_pkg::pos_dec(write_q);
          act_o.valid = 1'b1;
          act_o.act   = lerb_pkg::ACT_ERASE;
        end
      end else if (is_print && !full) begin
        do_write    = 1'b1;
        write_d     = lerb_pkg::pos_inc(write_q);
        if (ch == lerb_pkg::CH_LF) begin
          commit_d = write_d;
        end
        act_o.valid = 1'b1;
        act_o.act   = lerb_pkg::ACT_ECHO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_q   <= '0;
      write_q  <= '0;
      commit_q <= '0;
    end else begin
      read_q   <= read_d;
      write_q  <= write_d;
      commit_q <= commit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      char_store[lerb_pkg::pos_idx(write_q)] <= ch;
    end
    if (do_read) begin
      rd_q <= char_store[lerb_pkg::pos_idx(read_q)];
    end
  end

  assign rd_data_o = rd_q;

  a_commit_within_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lerb_pkg::pos_dist(read_q, commit_q) <= lerb_pkg::pos_dist(read_q, write_q))
    else $error("commit pointer ahead of write pointer");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lerb_pkg::pos_dist(read_q, write_q) <= lerb_pkg::DEPTH_X)
    else $error("ring holds more than its depth");

  a_erase_keeps_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_o.valid && (act_o.act == lerb_pkg::ACT_ERASE) |=> $stable(commit_q))
    else $error("backspace moved the commit pointer");

endmodule

`default_nettype wire

[sv/lerb_out.sv]
// result register that sequences one to three results per request
`default_nettype none

module lerb_out (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lerb_pkg::act_t act_i,
  input  wire logic [7:0]    rd_data_i,
  output logic               free_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [7:0]         m_axis_tdata,
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tlast
);

  lerb_pkg::act_t act_q;
  logic [1:0]     cnt_q;
  logic           valid_q;
  logic           last;

  always_comb begin
    m_axis_tdata = act_q.ch;
    m_axis_tuser = lerb_pkg::KIND_ECHO;
    last         = 1'b1;
    case (act_q.act)
      lerb_pkg::ACT_ECHO: begin
        m_axis_tdata = act_q.ch;
        m_axis_tuser = lerb_pkg::KIND_ECHO;
      end
      lerb_pkg::ACT_ERASE: begin
        m_axis_tdata = (cnt_q == 2'd1) ? lerb_pkg::CH_SP : lerb_pkg::CH_BS;
        m_axis_tuser = lerb_pkg::KIND_ECHO;
        last         = (cnt_q == 2'd2);
      end
      lerb_pkg::ACT_READ: begin
        m_axis_tdata = rd_data_i;
        m_axis_tuser = lerb_pkg::KIND_DATA;
      end
      lerb_pkg::ACT_EMPTY: begin
        m_axis_tdata = 8'h00;
        m_axis_tuser = lerb_pkg::KIND_NONE;
      end
      default: begin
        m_axis_tdata = 8'h00;
        m_axis_tuser = lerb_pkg::KIND_NONE;
      end
    endcase
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = last;
  assign free_o        = !valid_q || (m_axis_tready && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      act_q   <= '{valid: 1'b0, act: lerb_pkg::ACT_EMPTY, ch: 8'h00};
    end else if (free_o) begin
      valid_q <= act_i.valid;
      cnt_q   <= '0;
      if (act_i.valid) begin
        act_q <= act_i;
      end
    end else if (m_axis_tready) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  a_single_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (act_q.act != lerb_pkg::ACT_ERASE) |-> last)
    else $error("single result request without last");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (cnt_q != 2'd3))
    else $error("result counter out of range");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (m_axis_tuser == lerb_pkg::KIND_NONE) |-> (m_axis_tdata == 8'h00))
    else $error("empty read result carries data");

endmodule

`default_nettype wire

[sv/line_edit_receive_buffer.sv]
// top level of the canonical line edit receive buffer
// Each request is a received byte (tuser 0) or a read (tuser 1). Received
// bytes are edited into a ring of lerb_pkg::DEPTH characters and echoed;
// backspace or DEL erases the last uncommitted character and echoes BS,
// space, BS; CR is taken as LF and LF commits the line. A read returns the
// oldest committed character (tuser 1) or tuser 2 with data 0 if none is
// committed. Bytes that would overflow the ring are dropped silently.
// A request is taken while s_axis_tready is high; the single result port then sets the
// pace: a request that gives one result frees the input on the cycle that
// result is taken, a backspace holds it until the last of its three results is taken.
`default_nettype none

module line_edit_receive_buffer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // rx_byte
  input  wire logic       s_axis_tuser,   // op
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // data
  output logic [1:0]      m_axis_tuser,   // kind
  output logic            m_axis_tlast    // last
);

  lerb_pkg::act_t act;
  logic [7:0]     rd_data;
  logic           free;
  logic           accept;

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  lerb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (s_axis_tuser),
    .rx_byte_i (s_axis_tdata),
    .act_o     (act),
    .rd_data_o (rd_data)
  );

  lerb_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .act_i         (act),
    .rd_data_i     (rd_data),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[bench/lerb_checker.sv]
// checker that predicts the line editor's echo and read results and compares them
module lerb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_SPAN   = 2 * lerb_pkg::DEPTH;
  localparam int unsigned REPLY_SLOTS = 16;

  typedef struct packed {
    lerb_pkg::kind_e kind;
    logic [7:0]      data;
    logic            last;
  } reply_t;

  logic [7:0]  line_ring [lerb_pkg::DEPTH];
  int unsigned rd_pos;
  int unsigned wr_pos;
  int unsigned cm_pos;
  int unsigned mismatches;
  reply_t      reply_mem [REPLY_SLOTS];
  int unsigned reply_head;
  int unsigned reply_tail;
  int unsigned reply_count;
  reply_t      got;
  reply_t      want;

  function automatic int unsigned pos_next(input int unsigned p);
    return (p + 1) % RING_SPAN;
  endfunction

  function automatic int unsigned pos_prev(input int unsigned p);
    return (p + RING_SPAN - 1) % RING_SPAN;
  endfunction

  function automatic int unsigned ring_used(input int unsigned from, input int unsigned to);
    return (to + RING_SPAN - from) % RING_SPAN;
  endfunction

  task automatic note_mismatch(input string what, input reply_t exp_r, input reply_t act_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected kind %0d data %02h last %0b, got kind %0d data %02h last %0b",
               $time, what, exp_r.kind, exp_r.data, exp_r.last,
               act_r.kind, act_r.data, act_r.last);
    end
  endtask

  task automatic queue_reply(input lerb_pkg::kind_e kind, input logic [7:0] data,
                             input logic last);
    reply_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    if (reply_count == REPLY_SLOTS) begin
      note_mismatch("too many results pending", r, '0);
    end else begin
      reply_mem[reply_tail] = r;
      reply_tail = (reply_tail + 1) % REPLY_SLOTS;
      reply_count++;
    end
  endtask

  task automatic edit_line(input logic op, input logic [7:0] rx);
    logic [7:0] ch;
    ch = rx;
    if (op == lerb_pkg::OP_READ) begin
      if (rd_pos != cm_pos) begin
        queue_reply(lerb_pkg::KIND_DATA, line_ring[rd_pos % lerb_pkg::DEPTH], 1'b1);
        rd_pos = pos_next(rd_pos);
      end else begin
        queue_reply(lerb_pkg::KIND_NONE, 8'h00, 1'b1);
      end
    end else if (ch == lerb_pkg::CH_BS || ch == lerb_pkg::CH_DEL) begin
      if (wr_pos != cm_pos) begin
        wr_pos = pos_prev(wr_pos);
        queue_reply(lerb_pkg::KIND_ECHO, lerb_pkg::CH_BS, 1'b0);
        queue_reply(lerb_pkg::KIND_ECHO, lerb_pkg::CH_SP, 1'b0);
        queue_reply(lerb_pkg::KIND_ECHO, lerb_pkg::CH_BS, 1'b1);
      end
    end else begin
      if (ch == lerb_pkg::CH_CR) ch = lerb_pkg::CH_LF;
      // zero, high bytes, esc and other controls fall out here
      if ((ch == lerb_pkg::CH_LF ||
           (ch >= lerb_pkg::CH_SP && ch <= lerb_pkg::CH_TILDE)) &&
          ring_used(rd_pos, wr_pos) < lerb_pkg::DEPTH) begin
        line_ring[wr_pos % lerb_pkg::DEPTH] = ch;
        wr_pos = pos_next(wr_pos);
        if (ch == lerb_pkg::CH_LF) cm_pos = wr_pos;
        queue_reply(lerb_pkg::KIND_ECHO, ch, 1'b1);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pos = 0;
      wr_pos = 0;
      cm_pos = 0;
      mismatches = 0;
      reply_head = 0;
      reply_tail = 0;
      reply_count = 0;
      mismatch_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.kind = lerb_pkg::kind_e'(m_tuser_i);
        got.data = m_tdata_i;
        got.last = m_tlast_i;
        if (reply_count == 0) begin
          want = '0;
          note_mismatch("result with nothing pending", want, got);
        end else begin
          want = reply_mem[reply_head];
          reply_head = (reply_head + 1) % REPLY_SLOTS;
          reply_count--;
          if (want !== got) note_mismatch("result mismatch", want, got);
        end
      end
      if (s_tvalid_i && s_tready_i) edit_line(s_tuser_i, s_tdata_i);
      mismatch_cnt_o <= mismatches;
      pending_o <= reply_count;
    end
  end

endmodule

[bench/line_edit_receive_buffer_test.sv]
// stimulus and verdict for the line edit receive buffer
module line_edit_receive_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 30;
  localparam int unsigned CALM_ITEMS   = 12;
  localparam int unsigned FILL_READS   = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int unsigned mismatch_cnt;
  int unsigned pending;

  bit          calm;
  bit          hold_off;
  int unsigned active_cnt;
  int unsigned cyc;

  line_edit_receive_buffer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lerb_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tuser_i      (m_axis_tuser),
    .m_tlast_i      (m_axis_tlast),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] any_printable();
    return 8'($urandom_range(lerb_pkg::CH_SP, lerb_pkg::CH_TILDE));
  endfunction

  task automatic offer(input logic op, input logic [7:0] rx);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == lerb_pkg::OP_READ || rx == lerb_pkg::CH_LF || rx == lerb_pkg::CH_CR ||
        rx == lerb_pkg::CH_BS || rx == lerb_pkg::CH_DEL ||
        (rx >= lerb_pkg::CH_SP && rx <= lerb_pkg::CH_TILDE)) begin
      active_cnt++;
    end
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // fill the ring with an uncommitted line, hit the full cases, then read a few back
  task automatic fill_ring(input bit with_hold);
    pause_until_drained();
    if (with_hold) hold_off = 1'b1;
    for (int i = 0; i < lerb_pkg::DEPTH + 2; i++) offer(lerb_pkg::OP_RX, any_printable());
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_LF);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_DEL);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_CR);
    offer(lerb_pkg::OP_RX, any_printable());
    for (int i = 0; i < FILL_READS; i++) offer(lerb_pkg::OP_READ, 8'($urandom));
  endtask

  task automatic type_line();
    int unsigned len;
    int unsigned reads;
    int unsigned pick;
    len = $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        offer(lerb_pkg::OP_RX, $urandom_range(0, 1) ? lerb_pkg::CH_BS : lerb_pkg::CH_DEL);
      end else if (pick == 2) begin
        offer(lerb_pkg::OP_RX, 8'($urandom));
      end else begin
        offer(lerb_pkg::OP_RX, any_printable());
      end
    end
    offer(lerb_pkg::OP_RX, $urandom_range(0, 1) ? lerb_pkg::CH_LF : lerb_pkg::CH_CR);
    reads = $urandom_range(0, len + 3);
    for (int i = 0; i < reads; i++) offer(lerb_pkg::OP_READ, 8'($urandom));
  endtask

  // receiver side
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk_i);
    $display("line_edit_receive_buffer_test failed");
    $finish;
  end

  initial begin
    int unsigned base;
    calm = 1'b0;
    hold_off = 1'b0;
    active_cnt = 0;
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= lerb_pkg::OP_RX;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty read, ignored bytes, editing at the commit boundary
    offer(lerb_pkg::OP_READ, 8'hff);
    offer(lerb_pkg::OP_RX, 8'h00);
    offer(lerb_pkg::OP_RX, 8'hff);
    offer(lerb_pkg::OP_RX, 8'h80);
    offer(lerb_pkg::OP_RX, 8'h1b);
    offer(lerb_pkg::OP_RX, 8'h01);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_BS);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_DEL);
    offer(lerb_pkg::OP_RX, 8'h41);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_SP);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_TILDE);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_DEL);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_BS);
    offer(lerb_pkg::OP_RX, 8'h1f);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_CR);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_BS);
    offer(lerb_pkg::OP_READ, 8'h00);
    offer(lerb_pkg::OP_READ, 8'haa);
    offer(lerb_pkg::OP_READ, 8'h55);
    offer(lerb_pkg::OP_RX, 8'h62);
    offer(lerb_pkg::OP_RX, lerb_pkg::CH_LF);
    offer(lerb_pkg::OP_READ, 8'h0f);
    offer(lerb_pkg::OP_READ, 8'hf0);
    offer(lerb_pkg::OP_READ, 8'h00);

    fill_ring(1'b1);
    pause_until_drained();

    base = active_cnt;
    while (active_cnt < base + RANDOM_ITEMS) begin
      if (active_cnt >= base + RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 9) < 7) type_line();
      else if ($urandom_range(0, 1) == 0) offer(lerb_pkg::OP_READ, 8'($urandom));
      else offer(lerb_pkg::OP_RX, 8'($urandom));
    end

    pause_until_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("line_edit_receive_buffer_test passed");
    end else begin
      $display("line_edit_receive_buffer_test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/lerb_pkg.sv
sv/lerb_ctrl.sv
sv/lerb_out.sv
sv/line_edit_receive_buffer.sv
bench/lerb_checker.sv
bench/line_edit_receive_buffer_test.sv
